[rtl/tpsc_pkg.sv]
// Shared types, constants and the row base table for the text page scan capture.
// No dependencies; imported by every module of the block.
package tpsc_pkg;

  localparam int unsigned SCREEN_COLUMNS = 40;
  localparam int unsigned SCREEN_ROWS    = 24;
  localparam int unsigned CELLS          = SCREEN_COLUMNS * SCREEN_ROWS;

  localparam int unsigned ROW_W  = 5;
  localparam int unsigned COL_W  = 6;
  localparam int unsigned CELL_W = $clog2(CELLS);
  localparam int unsigned CODE_W = 7;
  localparam int unsigned ADDR_W = 16;

  localparam logic [ADDR_W-1:0] ADDR_RESET = 16'h0400;
  localparam logic [5:0]        CODE_MASK  = 6'b111111;
  localparam logic [CODE_W-1:0] CODE_LOW   = 7'h20;
  localparam logic [CODE_W-1:0] CODE_LIFT  = 7'h40;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_READ   = 1'b1
  } cmd_e;

  // Write request into the screen store
  typedef struct packed {
    logic              en;
    logic [CELL_W-1:0] addr;
    logic [CODE_W-1:0] data;
  } wr_req_t;

  // Current scan position and fill status of the store
  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [CELL_W-1:0] lin;
    logic              wrapped;
  } scan_pos_t;

  // Interleaved text page base of a row
  function automatic logic [ADDR_W-1:0] row_base(input logic [ROW_W-1:0] row);
    logic [ADDR_W-1:0] base;
    case (row)
      5'd0:    base = 16'h0400;
      5'd1:    base = 16'h0480;
      5'd2:    base = 16'h0500;
      5'd3:    base = 16'h0580;
      5'd4:    base = 16'h0600;
      5'd5:    base = 16'h0680;
      5'd6:    base = 16'h0700;
      5'd7:    base = 16'h0780;
      5'd8:    base = 16'h0428;
      5'd9:    base = 16'h04A8;
      5'd10:   base = 16'h0528;
      5'd11:   base = 16'h05A8;
      5'd12:   base = 16'h0628;
      5'd13:   base = 16'h06A8;
      5'd14:   base = 16'h0728;
      5'd15:   base = 16'h07A8;
      5'd16:   base = 16'h0450;
      5'd17:   base = 16'h04D0;
      5'd18:   base = 16'h0550;
      5'd19:   base = 16'h05D0;
      5'd20:   base = 16'h0650;
      5'd21:   base = 16'h06D0;
      5'd22:   base = 16'h0750;
      5'd23:   base = 16'h07D0;
      default: base = 16'h0400;
    endcase
    return base;
  endfunction

  // Row-major cell index: row * 40 + col as shifts and adds
  function automatic logic [CELL_W-1:0] cell_index(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
    logic [CELL_W-1:0] r;
    r = CELL_W'(row);
    return (r << 5) + (r << 3) + CELL_W'(col);
  endfunction

endpackage

[rtl/tpsc_store.sv]
// Screen store: 960 x 7 single-port-write memory with a registered read.
// Depends on tpsc_pkg for widths and the write request type.
module tpsc_store
  import tpsc_pkg::*;
(
  input  logic              clk_i,
  input  wr_req_t           wr_i,
  input  logic              rd_en_i,
  input  logic [CELL_W-1:0] rd_addr_i,
  output logic [CODE_W-1:0] rd_data_o
);

  logic [CODE_W-1:0] mem [CELLS];
  logic [CODE_W-1:0] rd_data_q;

  // Write one cell per enabled write request
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // Read one cell per accepted item, hold otherwise
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/tpsc_scan.sv]
// Scan control: phase-1 edge detect, column/row counters, fill index and fetch address.
// Depends on tpsc_pkg for the row base table, constants and structs.
module tpsc_scan
  import tpsc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              sample_i,     // accepted bus sample item
  input  logic              phase_level_i,
  input  logic [7:0]        bus_byte_i,
  output wr_req_t           wr_o,
  output scan_pos_t         pos_o,
  output logic              edge_o,
  output logic [CODE_W-1:0] code_o,
  output logic [ADDR_W-1:0] addr_o        // address after this item's update
);

  logic              phase_q, phase_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [CELL_W-1:0] lin_q, lin_d;
  logic              wrapped_q, wrapped_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic              falling;
  logic [5:0]        low6;
  logic [CODE_W-1:0] code;

  // Fold control codes up into the printable range
  always_comb begin
    low6 = bus_byte_i[5:0] & CODE_MASK;
    code = {1'b0, low6};
    if (code < CODE_LOW) begin
      code = code + CODE_LIFT;
    end
  end

  // Advance the position on a falling edge of phase 1
  always_comb begin
    falling   = sample_i && !phase_level_i && phase_q;
    phase_d   = sample_i ? phase_level_i : phase_q;
    row_d     = row_q;
    col_d     = col_q;
    lin_d     = lin_q;
    wrapped_d = wrapped_q;
    addr_d    = addr_q;
    if (falling) begin
      if (col_q == COL_W'(SCREEN_COLUMNS - 1)) begin
        col_d = '0;
        row_d = (row_q == ROW_W'(SCREEN_ROWS - 1)) ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
      if (lin_q == CELL_W'(CELLS - 1)) begin
        lin_d     = '0;
        wrapped_d = 1'b1;
      end else begin
        lin_d = lin_q + 1'b1;
      end
      addr_d = row_base(row_d) + ADDR_W'(col_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= 1'b0;
      row_q     <= '0;
      col_q     <= '0;
      lin_q     <= '0;
      wrapped_q <= 1'b0;
      addr_q    <= ADDR_RESET;
    end else begin
      phase_q   <= phase_d;
      row_q     <= row_d;
      col_q     <= col_d;
      lin_q     <= lin_d;
      wrapped_q <= wrapped_d;
      addr_q    <= addr_d;
    end
  end

  assign wr_o.en       = falling;
  assign wr_o.addr     = lin_q;
  assign wr_o.data     = code;
  assign pos_o.row     = row_q;
  assign pos_o.col     = col_q;
  assign pos_o.lin     = lin_q;
  assign pos_o.wrapped = wrapped_q;
  assign edge_o        = falling;
  assign code_o        = falling ? code : '0;
  assign addr_o        = addr_d;

endmodule

[rtl/text_page_scan_capture.sv]
// Text page scan capture: one item per cycle while the output is not stalled, set by
// the single store write and read port and the one output register; the result is
// registered in the cycle after acceptance. Reset clears the counters, sets the fetch
// address to 0x400 and empties the store at once: a fill index marks which cells were
// written since reset, and unwritten cells read as zero. No clearing pass is run.
module text_page_scan_capture
  import tpsc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              command_i,
  input  logic              phase_level_i,
  input  logic [7:0]        bus_byte_i,
  input  logic [ROW_W-1:0]  read_row_i,
  input  logic [COL_W-1:0]  read_column_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ADDR_W-1:0] fetch_address_o,
  output logic              edge_taken_o,
  output logic [CODE_W-1:0] written_code_o,
  output logic [CODE_W-1:0] cell_code_o
);

  logic              accept;
  logic              is_read;
  logic              in_range;
  logic              cell_live;
  logic [CELL_W-1:0] rd_addr;
  logic [CODE_W-1:0] rd_data;
  wr_req_t           wr;
  scan_pos_t         pos;
  logic              scan_edge;
  logic [CODE_W-1:0] scan_code;
  logic [ADDR_W-1:0] scan_addr;

  logic              out_valid_q;
  logic [ADDR_W-1:0] fetch_q;
  logic              edge_q;
  logic [CODE_W-1:0] written_q;
  logic              cell_live_q;

  // Take a new item whenever the output register is free or draining
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_read    = command_i == CMD_READ;

  tpsc_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sample_i     (accept && !is_read),
    .phase_level_i(phase_level_i),
    .bus_byte_i   (bus_byte_i),
    .wr_o         (wr),
    .pos_o        (pos),
    .edge_o       (scan_edge),
    .code_o       (scan_code),
    .addr_o       (scan_addr)
  );

  // A cell counts only if in range and written since reset
  always_comb begin
    in_range  = (read_row_i < ROW_W'(SCREEN_ROWS)) && (read_column_i < COL_W'(SCREEN_COLUMNS));
    rd_addr   = cell_index(read_row_i, read_column_i);
    cell_live = is_read && in_range && (pos.wrapped || (rd_addr < pos.lin));
  end

  tpsc_store u_store (
    .clk_i    (clk_i),
    .wr_i     (wr),
    .rd_en_i  (accept && is_read),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  // Output register: hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fetch_q     <= scan_addr;
      edge_q      <= scan_edge;
      written_q   <= scan_code;
      cell_live_q <= cell_live;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign fetch_address_o = fetch_q;
  assign edge_taken_o    = edge_q;
  assign written_code_o  = written_q;
  assign cell_code_o     = cell_live_q ? rd_data : '0;

`ifndef SYNTHESIS
  // Fill index tracks the row and column counters
  a_lin_matches_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos.lin == cell_index(pos.row, pos.col))
    else $error("fill index out of step with row/column");

  // Position always stays on the screen
  a_pos_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos.row < ROW_W'(SCREEN_ROWS)) && (pos.col < COL_W'(SCREEN_COLUMNS)))
    else $error("scan position off screen");

  // An edge result carries a printable code and no cell read
  a_edge_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && edge_taken_o |->
      (written_code_o >= CODE_LOW) && (written_code_o < 7'h60) && (cell_code_o == '0))
    else $error("edge result with bad code or cell data");

  // A read result with a nonzero cell code never reports an edge
  a_read_no_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (cell_code_o != '0) |-> !edge_taken_o && (written_code_o == '0))
    else $error("read result mixed with edge result");
`endif

endmodule

[test/testbench.sv]
// Testbench for text_page_scan_capture: drives sample and read items through the
// valid/ready channels and checks every output item against a screen mirror.
// Depends on tpsc_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module testbench;
  import tpsc_pkg::*;

  typedef struct {
    cmd_e              command;
    logic              phase;
    logic [7:0]        bus;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } scan_item_t;

  typedef struct {
    logic [ADDR_W-1:0] address;
    logic              took_edge;
    logic [CODE_W-1:0] written;
    logic [CODE_W-1:0] read_code;
  } scan_out_t;

  // Mirror of the scan position, fetch address and screen; holds awaited outputs
  class text_page_mirror;
    logic              phase_prev;
    int unsigned       col;
    int unsigned       row;
    logic [ADDR_W-1:0] address;
    logic [CODE_W-1:0] screen [SCREEN_ROWS][SCREEN_COLUMNS];
    scan_out_t         awaited[$];
    int unsigned       mismatches;

    function new();
      phase_prev = 1'b0;
      col        = 0;
      row        = 0;
      address    = ADDR_RESET;
      mismatches = 0;
      foreach (screen[r, c]) screen[r][c] = '0;
    endfunction

    // Apply one accepted item and queue the output it should produce
    function void take_item(scan_item_t it);
      scan_out_t         want;
      logic [CODE_W-1:0] code;
      want.took_edge = 1'b0;
      want.written   = '0;
      want.read_code = '0;
      if (it.command == CMD_SAMPLE) begin
        if (phase_prev && !it.phase) begin
          // Keep the low six bits, lift control codes into the printable range
          code = {1'b0, it.bus[5:0] & CODE_MASK};
          if (code < CODE_LOW) code = code + CODE_LIFT;
          screen[row][col] = code;
          col++;
          if (col == SCREEN_COLUMNS) begin
            col = 0;
            row = (row + 1) % SCREEN_ROWS;
          end
          // Rows interleave in groups of eight: 0x80 apart, groups 0x28 apart
          address = ADDR_W'(ADDR_RESET + (row % 8) * 'h80 + (row / 8) * 'h28 + col);
          want.took_edge = 1'b1;
          want.written   = code;
        end
        phase_prev = it.phase;
      end else if (it.row < SCREEN_ROWS && it.col < SCREEN_COLUMNS) begin
        want.read_code = screen[it.row][it.col];
      end
      want.address = address;
      awaited.push_back(want);
    endfunction

    // Compare one accepted output item with the oldest awaited one
    function void match_output(scan_out_t got);
      scan_out_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output: addr %h edge %b written %h cell %h",
                   got.address, got.took_edge, got.written, got.read_code);
        return;
      end
      want = awaited.pop_front();
      if (got.address !== want.address || got.took_edge !== want.took_edge ||
          got.written !== want.written || got.read_code !== want.read_code) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch at %0t: addr %h/%h edge %b/%b written %h/%h cell %h/%h (exp/got)",
                   $realtime, want.address, got.address, want.took_edge, got.took_edge,
                   want.written, got.written, want.read_code, got.read_code);
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              command_i;
  logic              phase_level_i;
  logic [7:0]        bus_byte_i;
  logic [ROW_W-1:0]  read_row_i;
  logic [COL_W-1:0]  read_column_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [ADDR_W-1:0] fetch_address_o;
  logic              edge_taken_o;
  logic [CODE_W-1:0] written_code_o;
  logic [CODE_W-1:0] cell_code_o;

  text_page_mirror mirror = new();
  scan_out_t       seen_out;
  int unsigned     send_idle_pct;
  int unsigned     stall_pct;
  logic            last_level;

  int unsigned idle_by_phase[4]  = '{0, 85, 0, 33};
  int unsigned stall_by_phase[4] = '{0, 0, 85, 33};

  text_page_scan_capture u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .phase_level_i   (phase_level_i),
    .bus_byte_i      (bus_byte_i),
    .read_row_i      (read_row_i),
    .read_column_i   (read_column_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .fetch_address_o (fetch_address_o),
    .edge_taken_o    (edge_taken_o),
    .written_code_o  (written_code_o),
    .cell_code_o     (cell_code_o)
  );

  // Generate the clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stall the output channel at the current rate
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Check every accepted output item
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_out = '{fetch_address_o, edge_taken_o, written_code_o, cell_code_o};
      mirror.match_output(seen_out);
    end
  end

  function automatic scan_item_t make_sample(logic lvl, logic [7:0] bus);
    scan_item_t it;
    it.command = CMD_SAMPLE;
    it.phase   = lvl;
    it.bus     = bus;
    it.row     = '0;
    it.col     = '0;
    last_level = lvl;
    return it;
  endfunction

  function automatic scan_item_t make_read(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
    scan_item_t it;
    it.command = CMD_READ;
    it.phase   = 1'b0;
    it.bus     = '0;
    it.row     = row;
    it.col     = col;
    return it;
  endfunction

  // Mostly alternating clock samples so edges keep coming; reads favor written cells
  function automatic scan_item_t random_item();
    scan_item_t  it;
    int unsigned pick;
    it.bus   = $urandom_range(0, 255);
    it.phase = $urandom_range(0, 1);
    it.row   = $urandom_range(0, 31);
    it.col   = $urandom_range(0, 63);
    if ($urandom_range(0, 99) < 20) begin
      it.command = CMD_READ;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        it.row = $urandom_range(0, mirror.row);
        it.col = $urandom_range(0, SCREEN_COLUMNS - 1);
      end else if (pick < 75) begin
        it.row = $urandom_range(0, SCREEN_ROWS - 1);
        it.col = $urandom_range(0, SCREEN_COLUMNS - 1);
      end
    end else begin
      it.command = CMD_SAMPLE;
      if ($urandom_range(0, 99) < 80) it.phase = ~last_level;
      last_level = it.phase;
    end
    return it;
  endfunction

  // Offer one item, hold it until accepted; entered and left at a falling edge
  task automatic send_item(scan_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= it.command;
    phase_level_i <= it.phase;
    bus_byte_i    <= it.bus;
    read_row_i    <= it.row;
    read_column_i <= it.col;
    do @(posedge clk_i); while (!in_ready_o);
    mirror.take_item(it);
    @(negedge clk_i);
  endtask

  // Hold off the sender until every awaited output item has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (mirror.awaited.size() != 0);
  endtask

  // Give up on a hung run
  initial begin
    #(2_000_000);
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    out_ready_i   = 1'b0;
    command_i     = CMD_SAMPLE;
    phase_level_i = 1'b0;
    bus_byte_i    = '0;
    read_row_i    = '0;
    read_column_i = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    last_level    = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Cleared store, out-of-range reads, edge detection and code mapping
    send_item(make_read(0, 0));
    send_item(make_read(31, 63));
    send_item(make_sample(1'b0, 8'hFF));
    send_item(make_sample(1'b1, 8'h00));
    send_item(make_read(0, 0));
    send_item(make_sample(1'b0, 8'h00));
    send_item(make_sample(1'b0, 8'hFF));
    send_item(make_sample(1'b1, 8'hFF));
    send_item(make_sample(1'b1, 8'h00));
    send_item(make_sample(1'b0, 8'hFF));
    send_item(make_sample(1'b1, 8'h00));
    send_item(make_sample(1'b0, 8'h1F));
    send_item(make_sample(1'b1, 8'h00));
    send_item(make_sample(1'b0, 8'h20));
    send_item(make_sample(1'b1, 8'h00));
    send_item(make_sample(1'b0, 8'hC0));
    send_item(make_read(0, 0));
    send_item(make_read(0, 1));
    send_item(make_read(0, 2));
    send_item(make_read(0, 4));
    send_item(make_read(23, 39));
    send_item(make_read(24, 0));
    send_item(make_read(0, 40));
    drain();

    // Random items under each idling pattern, emptying the block between them
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_by_phase[p];
      stall_pct     = stall_by_phase[p];
      repeat (135) send_item(random_item());
      drain();
    end

    repeat (4) @(posedge clk_i);
    if (mirror.mismatches == 0 && mirror.awaited.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
